FILE: src/pagc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pagc_pkg
// Shared codes and types of the peer address group classifier: network kinds,
// class codes, group key selection and the address decode flags.
// ----------------------------------------------------------------------------
package pagc_pkg;

  // Stored network kinds.
  localparam logic [1:0] KIND_IPV4     = 2'd0;
  localparam logic [1:0] KIND_IPV6     = 2'd1;
  localparam logic [1:0] KIND_ONION    = 2'd2;
  localparam logic [1:0] KIND_INTERNAL = 2'd3;

  // Class codes, also the first byte of the group key.
  localparam logic [2:0] CLASS_UNROUTABLE = 3'd0;
  localparam logic [2:0] CLASS_IPV4       = 3'd1;
  localparam logic [2:0] CLASS_IPV6       = 3'd2;
  localparam logic [2:0] CLASS_ONION      = 3'd3;
  localparam logic [2:0] CLASS_INTERNAL   = 3'd4;

  localparam logic [3:0] LEN_INTERNAL = 4'd11;
  localparam logic [3:0] LEN_NONE     = 4'd1;
  localparam logic [3:0] LEN_V4       = 4'd3;
  localparam logic [3:0] LEN_ONION    = 4'd2;
  localparam logic [3:0] LEN_V6       = 4'd5;
  localparam logic [3:0] LEN_V6_EXT   = 4'd6;

  localparam logic [7:0] LOW_NIBBLE_SET = 8'h0F;

  // Which part of the address follows the class byte in the group key.
  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_INTERNAL,
    KEY_V4,
    KEY_6TO4,
    KEY_TEREDO,
    KEY_ONION,
    KEY_V6_EXT,
    KEY_V6
  } key_sel_t;

  // Prefix and range matches on the raw address, not yet qualified by kind.
  typedef struct packed {
    logic v4_invalid;
    logic v4_local;
    logic v4_priv;
    logic v4_reserved;
    logic v6_invalid;
    logic v6_local;
    logic v6_reserved;
    logic v6_siit;
    logic v6_nat64;
    logic v6_6to4;
    logic v6_teredo;
    logic v6_ext;
  } addr_flags_t;

endpackage
`default_nettype wire

FILE: src/pagc_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pagc_decode
// Compares the raw 128-bit address against the special IPv4 and IPv6 ranges
// and returns one flag per range family.
// ----------------------------------------------------------------------------
module pagc_decode (
  input  wire logic [63:0]          addr_high,
  input  wire logic [63:0]          addr_low,
  output pagc_pkg::addr_flags_t     flags
);
  import pagc_pkg::*;

  logic [7:0] a0, a1, a2, a3;
  logic [7:0] a12, a13, a14;
  logic       orchid_base;

  assign a0  = addr_high[63:56];
  assign a1  = addr_high[55:48];
  assign a2  = addr_high[47:40];
  assign a3  = addr_high[39:32];
  assign a12 = addr_low[31:24];
  assign a13 = addr_low[23:16];
  assign a14 = addr_low[15:8];

  assign orchid_base = (a0 == 8'h20) && (a1 == 8'h01) && (a2 == 8'h00);

  always_comb begin
    // IPv4 lives in bytes 12 to 15.
    flags.v4_invalid = (addr_low[31:0] == 32'hFFFF_FFFF) || (addr_low[31:0] == 32'h0);
    flags.v4_local   = (a12 == 8'd127) || (a12 == 8'd0);
    flags.v4_priv    = (a12 == 8'd10) ||
                       ((a12 == 8'd192) && (a13 == 8'd168)) ||
                       ((a12 == 8'd172) && (a13[7:4] == 4'h1));
    flags.v4_reserved = ((a12 == 8'd198) && ((a13 == 8'd18) || (a13 == 8'd19))) ||
                        ((a12 == 8'd169) && (a13 == 8'd254)) ||
                        ((a12 == 8'd100) && (a13[7:6] == 2'b01)) ||
                        ((a12 == 8'd192) && (a13 == 8'd0) && (a14 == 8'd2)) ||
                        ((a12 == 8'd198) && (a13 == 8'd51) && (a14 == 8'd100)) ||
                        ((a12 == 8'd203) && (a13 == 8'd0) && (a14 == 8'd113));

    // A misaligned record shows seven zero bytes followed by ff ff.
    flags.v6_invalid = ((addr_high[63:8] == 56'h0) && (addr_high[7:0] == 8'hFF) &&
                        (addr_low[63:56] == 8'hFF)) ||
                       ((addr_high == 64'h0) && (addr_low == 64'h0)) ||
                       (addr_high[63:32] == 32'h2001_0DB8);
    flags.v6_local   = (addr_high == 64'h0) && (addr_low == 64'h1);
    flags.v6_reserved = (addr_high == 64'hFE80_0000_0000_0000) ||
                        (a0[7:1] == 7'b1111_110) ||
                        (orchid_base && (a3[7:4] == 4'h1)) ||
                        (orchid_base && (a3[7:4] == 4'h2));
    flags.v6_siit    = (addr_high == 64'h0) && (addr_low[63:32] == 32'hFFFF_0000);
    flags.v6_nat64   = (addr_high == 64'h0064_FF9B_0000_0000) &&
                       (addr_low[63:32] == 32'h0);
    flags.v6_6to4    = (addr_high[63:48] == 16'h2002);
    flags.v6_teredo  = (addr_high[63:32] == 32'h2001_0000);
    flags.v6_ext     = (addr_high[63:32] == 32'h2001_0470);
  end

endmodule
`default_nettype wire

FILE: src/peer_address_group_classifier_top.sv
`default_nettype none
// Throughput: one beat per cycle while out_stall is low; three register stages
// (range decode, classification, group key build) each take a new beat every
// cycle when not held by a stall.
// A stall on the output backs up through the stages, filling bubbles first.
// Reset clears the stage valid bits and the private-range enable.
// ----------------------------------------------------------------------------
// peer_address_group_classifier_top
// Classifies a peer address by network, checks validity and reserved ranges,
// and builds the group key used to spread peers across address groups.
// ----------------------------------------------------------------------------
module peer_address_group_classifier_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  net_kind,
  input  wire logic [63:0] addr_high,
  input  wire logic [63:0] addr_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       peer_class,
  output logic             is_valid,
  output logic             is_routable,
  output logic             is_local,
  output logic [3:0]       group_len,
  output logic [63:0]      group_high,
  output logic [23:0]      group_low
);
  import pagc_pkg::*;

  logic allow_private_net;

  // Stage 1: address and decode flags.
  addr_flags_t dec_flags;
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [63:0] s1_high;
  logic [63:0] s1_low;
  addr_flags_t s1_flags;

  // Stage 2: classification.
  logic        s2_valid;
  key_sel_t    s2_sel;
  logic [2:0]  s2_class;
  logic        s2_is_valid;
  logic        s2_routable;
  logic        s2_local;
  logic [63:0] s2_high;
  logic [63:0] s2_low;

  logic en1, en2, en3;

  key_sel_t   sel_next;
  logic [2:0] class_next;
  logic       valid_next;
  logic       routable_next;
  logic       local_next;
  logic       reserved;
  logic       v4, v6, onion, internal;

  logic [3:0]  len_next;
  logic [63:0] gh_next;
  logic [23:0] gl_next;
  logic [7:0]  cls_byte;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_private_net <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_private_net <= cfg_wr_data;
    end
  end

  pagc_decode u_decode (
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .flags     (dec_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
    if (en1 && in_valid) begin
      s1_kind  <= net_kind;
      s1_high  <= addr_high;
      s1_low   <= addr_low;
      s1_flags <= dec_flags;
    end
  end

  always_comb begin
    v4       = (s1_kind == KIND_IPV4);
    v6       = (s1_kind == KIND_IPV6);
    onion    = (s1_kind == KIND_ONION);
    internal = (s1_kind == KIND_INTERNAL);

    valid_next    = !(v6 && s1_flags.v6_invalid) && !internal &&
                    !(v4 && s1_flags.v4_invalid);
    local_next    = (v4 && s1_flags.v4_local) || (v6 && s1_flags.v6_local);
    reserved      = (v4 && s1_flags.v4_reserved) || (v6 && s1_flags.v6_reserved) ||
                    local_next || internal;
    routable_next = valid_next && !(!allow_private_net && v4 && s1_flags.v4_priv) &&
                    !reserved;

    if (internal) begin
      sel_next   = KEY_INTERNAL;
      class_next = CLASS_INTERNAL;
    end else if (!routable_next) begin
      sel_next   = KEY_NONE;
      class_next = CLASS_UNROUTABLE;
    end else if (v4 || (v6 && (s1_flags.v6_siit || s1_flags.v6_nat64))) begin
      sel_next   = KEY_V4;
      class_next = CLASS_IPV4;
    end else if (v6 && s1_flags.v6_6to4) begin
      sel_next   = KEY_6TO4;
      class_next = CLASS_IPV4;
    end else if (v6 && s1_flags.v6_teredo) begin
      sel_next   = KEY_TEREDO;
      class_next = CLASS_IPV4;
    end else if (onion) begin
      sel_next   = KEY_ONION;
      class_next = CLASS_ONION;
    end else if (s1_flags.v6_ext) begin
      sel_next   = KEY_V6_EXT;
      class_next = CLASS_IPV6;
    end else begin
      sel_next   = KEY_V6;
      class_next = CLASS_IPV6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
    if (en2 && s1_valid) begin
      s2_sel      <= sel_next;
      s2_class    <= class_next;
      s2_is_valid <= valid_next;
      s2_routable <= routable_next;
      s2_local    <= local_next;
      s2_high     <= s1_high;
      s2_low      <= s1_low;
    end
  end

  // Stage 3: assemble the key; unused trailing bytes stay zero.
  always_comb begin
    cls_byte = {5'b0, s2_class};
    gl_next  = 24'h0;
    case (s2_sel)
      KEY_INTERNAL: begin
        len_next = LEN_INTERNAL;
        gh_next  = {cls_byte, s2_high[15:0], s2_low[63:24]};
        gl_next  = s2_low[23:0];
      end
      KEY_V4: begin
        len_next = LEN_V4;
        gh_next  = {cls_byte, s2_low[31:16], 40'h0};
      end
      KEY_6TO4: begin
        len_next = LEN_V4;
        gh_next  = {cls_byte, s2_high[47:32], 40'h0};
      end
      KEY_TEREDO: begin
        len_next = LEN_V4;
        gh_next  = {cls_byte, ~s2_low[31:16], 40'h0};
      end
      KEY_ONION: begin
        len_next = LEN_ONION;
        gh_next  = {cls_byte, s2_high[15:8] | LOW_NIBBLE_SET, 48'h0};
      end
      KEY_V6_EXT: begin
        len_next = LEN_V6_EXT;
        gh_next  = {cls_byte, s2_high[63:32], s2_high[31:24] | LOW_NIBBLE_SET, 16'h0};
      end
      KEY_V6: begin
        len_next = LEN_V6;
        gh_next  = {cls_byte, s2_high[63:32], 24'h0};
      end
      default: begin
        len_next = LEN_NONE;
        gh_next  = {cls_byte, 56'h0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= s2_valid;
    end
    if (en3 && s2_valid) begin
      peer_class  <= s2_class;
      is_valid    <= s2_is_valid;
      is_routable <= s2_routable;
      is_local    <= s2_local;
      group_len   <= len_next;
      group_high  <= gh_next;
      group_low   <= gl_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled while the first stage is empty");

  a_routable_is_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_routable |-> is_valid)
    else $error("routable result that is not valid");

  a_class_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> group_high[63:56] == {5'b0, peer_class})
    else $error("group key does not open with the class byte");

  a_internal_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && peer_class == CLASS_INTERNAL |-> group_len == LEN_INTERNAL && !is_valid)
    else $error("internal address with wrong key length or marked valid");

  a_unroutable_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && peer_class == CLASS_UNROUTABLE |->
      group_len == LEN_NONE && group_high[55:0] == 56'h0 && group_low == 24'h0 &&
      !is_routable)
    else $error("unroutable result with a non-empty key");
`endif

endmodule
`default_nettype wire

FILE: bench/peer_address_group_classifier_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_address_group_classifier_top_test
// Self-checking bench for the peer address group classifier. A table of
// directed addresses (empty, loopback, misaligned, documentation, tunnelled
// and internal cases) is followed by four random phases with the private-range
// enable toggled between them; ports idle and stall at random but in the third.
// Results are checked field by field against typed rows or the bench classifier.
// ----------------------------------------------------------------------------
module peer_address_group_classifier_top_test;
  import pagc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_BEATS = 456;
  localparam int TAIL_CYCLES = 8;
  localparam int DIRECTED_ROWS = 24;
  localparam logic PHASE_ENABLE [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

  typedef struct packed {
    logic [2:0]  peer_class;
    logic        valid_addr;
    logic        routable;
    logic        local_addr;
    logic [3:0]  group_len;
    logic [63:0] group_high;
    logic [23:0] group_low;
  } peer_group_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        typed;
    peer_group_t group;
  } addr_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  net_kind = KIND_IPV4;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  peer_class;
  logic        is_valid;
  logic        is_routable;
  logic        is_local;
  logic [3:0]  group_len;
  logic [63:0] group_high;
  logic [23:0] group_low;

  peer_group_t expected_groups [$];
  logic        allow_private = 1'b0;
  logic        tx_gaps = 1'b1;
  logic        rx_gaps = 1'b1;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          cycles = 0;
  int          class_seen [8] = '{default: 0};

  logic [7:0] v4_first [10] = '{8'd0, 8'd10, 8'd100, 8'd127, 8'd169, 8'd172, 8'd192,
                                8'd198, 8'd203, 8'd255};
  logic [7:0] v4_second [15] = '{8'd0, 8'd15, 8'd16, 8'd18, 8'd19, 8'd31, 8'd32, 8'd51,
                                 8'd63, 8'd64, 8'd127, 8'd128, 8'd168, 8'd254, 8'd255};
  logic [7:0] v4_third [4] = '{8'd0, 8'd2, 8'd100, 8'd113};

  // Rows marked as typed carry a result that can be read straight off the rules.
  addr_row_t directed_rows [DIRECTED_ROWS] = '{
    '{KIND_IPV4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 1'b1,
      '{CLASS_UNROUTABLE, 1'b0, 1'b0, 1'b1, LEN_NONE, 64'h0, 24'h0}},
    '{KIND_IPV4, 64'h0, 64'h0000_0000_FFFF_FFFF, 1'b1,
      '{CLASS_UNROUTABLE, 1'b0, 1'b0, 1'b0, LEN_NONE, 64'h0, 24'h0}},
    '{KIND_IPV6, 64'h0, 64'h0, 1'b1,
      '{CLASS_UNROUTABLE, 1'b0, 1'b0, 1'b0, LEN_NONE, 64'h0, 24'h0}},
    '{KIND_IPV6, 64'h0, 64'h1, 1'b1,
      '{CLASS_UNROUTABLE, 1'b1, 1'b0, 1'b1, LEN_NONE, 64'h0, 24'h0}},
    '{KIND_IPV6, 64'h0000_0000_0000_00FF, 64'hFF00_0000_0A00_0001, 1'b1,
      '{CLASS_UNROUTABLE, 1'b0, 1'b0, 1'b0, LEN_NONE, 64'h0, 24'h0}},
    '{KIND_IPV6, 64'h2001_0DB8_0000_0000, 64'h1, 1'b1,
      '{CLASS_UNROUTABLE, 1'b0, 1'b0, 1'b0, LEN_NONE, 64'h0, 24'h0}},
    '{KIND_INTERNAL, 64'h0, 64'h0, 1'b1,
      '{CLASS_INTERNAL, 1'b0, 1'b0, 1'b0, LEN_INTERNAL, 64'h0400_0000_0000_0000, 24'h0}},
    '{KIND_INTERNAL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{CLASS_INTERNAL, 1'b0, 1'b0, 1'b0, LEN_INTERNAL, 64'h04FF_FFFF_FFFF_FFFF,
        24'hFF_FFFF}},
    '{KIND_IPV4, 64'h0, 64'h0000_0000_7F00_0001, 1'b0, '0},
    '{KIND_IPV4, 64'h0, 64'h0000_0000_0A00_0001, 1'b0, '0},
    '{KIND_IPV4, 64'h1234_5678_9ABC_DEF0, 64'h0000_0000_AC1F_FFFF, 1'b0, '0},
    '{KIND_IPV4, 64'h0, 64'h0000_0000_C0A8_0001, 1'b0, '0},
    '{KIND_IPV4, 64'h0, 64'h0000_0000_0808_0808, 1'b0, '0},
    '{KIND_IPV6, 64'hFE80_0000_0000_0000, 64'h1, 1'b0, '0},
    '{KIND_IPV6, 64'hFD00_0000_0000_0000, 64'h1, 1'b0, '0},
    '{KIND_IPV6, 64'h2001_0010_0000_0000, 64'h0, 1'b0, '0},
    '{KIND_IPV6, 64'h0, 64'hFFFF_0000_0102_0304, 1'b0, '0},
    '{KIND_IPV6, 64'h0064_FF9B_0000_0000, 64'h0000_0000_0506_0708, 1'b0, '0},
    '{KIND_IPV6, 64'h2002_C000_0201_0000, 64'h1, 1'b0, '0},
    '{KIND_IPV6, 64'h2001_0000_4136_E378, 64'h8000_F227_3FF5_3F2E, 1'b0, '0},
    '{KIND_IPV6, 64'h2001_0470_1F23_0000, 64'h2, 1'b0, '0},
    '{KIND_IPV6, 64'h2A00_1450_4001_0800, 64'h200E, 1'b0, '0},
    '{KIND_IPV6, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{KIND_ONION, 64'hDEAD_BEEF_0123_4567, 64'h89AB_CDEF_FEDC_BA98, 1'b0, '0}
  };

  peer_address_group_classifier_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .net_kind   (net_kind),
    .addr_high  (addr_high),
    .addr_low   (addr_low),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .peer_class (peer_class),
    .is_valid   (is_valid),
    .is_routable(is_routable),
    .is_local   (is_local),
    .group_len  (group_len),
    .group_high (group_high),
    .group_low  (group_low)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic peer_group_t classify_peer(input logic [1:0] kind,
                                                input logic [63:0] hi,
                                                input logic [63:0] lo,
                                                input logic allow_priv);
    peer_group_t r;
    logic [127:0] ab;
    logic [7:0] key [11];
    logic [7:0] o1, o2, o3;
    logic v4, v6, onion, internal, valid, loc, priv, reserved, routable;
    logic siit, nat64, six_to_four, teredo;
    int n;
    ab = {hi, lo};
    v4 = kind == KIND_IPV4;
    v6 = kind == KIND_IPV6;
    onion = kind == KIND_ONION;
    internal = kind == KIND_INTERNAL;
    // An ipv4 address lives in the last four bytes only.
    o1 = lo[31:24];
    o2 = lo[23:16];
    o3 = lo[15:8];

    valid = !(internal
              || (v6 && hi == 64'hFF && lo[63:56] == 8'hFF)
              || (v6 && ab == '0)
              || (v6 && hi[63:32] == 32'h2001_0DB8)
              || (v4 && (lo[31:0] == '1 || lo[31:0] == '0)));
    loc = (v4 && (o1 == 8'd127 || o1 == 8'd0)) || (v6 && ab == 128'd1);
    priv = v4 && (o1 == 8'd10 || (o1 == 8'd192 && o2 == 8'd168)
                  || (o1 == 8'd172 && o2 >= 8'd16 && o2 <= 8'd31));
    reserved = loc || internal
               || (v4 && o1 == 8'd198 && (o2 == 8'd18 || o2 == 8'd19))
               || (v4 && o1 == 8'd169 && o2 == 8'd254)
               || (v4 && o1 == 8'd100 && o2 >= 8'd64 && o2 <= 8'd127)
               || (v4 && {o1, o2, o3} == {8'd192, 8'd0, 8'd2})
               || (v4 && {o1, o2, o3} == {8'd198, 8'd51, 8'd100})
               || (v4 && {o1, o2, o3} == {8'd203, 8'd0, 8'd113})
               || (v6 && hi == 64'hFE80_0000_0000_0000)
               || (v6 && hi[63:57] == 7'b1111_110)
               || (v6 && hi[63:40] == 24'h20_0100
                   && (hi[39:36] == 4'h1 || hi[39:36] == 4'h2));
    routable = valid && !(priv && !allow_priv) && !reserved;

    siit = v6 && hi == '0 && lo[63:32] == 32'hFFFF_0000;
    nat64 = v6 && hi == 64'h0064_FF9B_0000_0000 && lo[63:32] == '0;
    six_to_four = v6 && hi[63:48] == 16'h2002;
    teredo = v6 && hi[63:32] == 32'h2001_0000;

    if (internal)
      r.peer_class = CLASS_INTERNAL;
    else if (!routable)
      r.peer_class = CLASS_UNROUTABLE;
    else if (v4 || siit || nat64 || six_to_four || teredo)
      r.peer_class = CLASS_IPV4;
    else if (onion)
      r.peer_class = CLASS_ONION;
    else
      r.peer_class = CLASS_IPV6;

    foreach (key[i]) key[i] = '0;
    key[0] = {5'd0, r.peer_class};
    n = 1;
    if (internal) begin
      for (int j = 6; j < 16; j++) key[j - 5] = ab[127 - 8 * j -: 8];
      n = 11;
    end else if (!routable) begin
      n = 1;
    end else if (v4 || siit || nat64) begin
      key[1] = o1;
      key[2] = o2;
      n = 3;
    end else if (six_to_four) begin
      key[1] = hi[47:40];
      key[2] = hi[39:32];
      n = 3;
    end else if (teredo) begin
      key[1] = ~o1;
      key[2] = ~o2;
      n = 3;
    end else if (onion) begin
      key[1] = hi[15:8] | 8'h0F;
      n = 2;
    end else begin
      for (int j = 0; j < 4; j++) key[j + 1] = hi[63 - 8 * j -: 8];
      n = 5;
      // One provider's prefix is grouped more finely, by a /36.
      if (hi[63:32] == 32'h2001_0470) begin
        key[5] = hi[31:24] | 8'h0F;
        n = 6;
      end
    end

    r.valid_addr = valid;
    r.routable = routable;
    r.local_addr = loc;
    r.group_len = n[3:0];
    r.group_high = {key[0], key[1], key[2], key[3], key[4], key[5], key[6], key[7]};
    r.group_low = {key[8], key[9], key[10]};
    return r;
  endfunction

  // Mostly well-formed prefixes with random content, some plain noise, and now
  // and then a single flipped bit in the upper half to make near misses.
  task automatic draw_address(output logic [1:0] kind, output logic [63:0] hi,
                              output logic [63:0] lo);
    kind = KIND_IPV6;
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: kind = 2'($urandom_range(0, 3));
      1: kind = KIND_IPV4;
      2, 3: begin
        kind = KIND_IPV4;
        lo[31:24] = v4_first[$urandom_range(0, 9)];
        lo[23:16] = v4_second[$urandom_range(0, 14)];
        if ($urandom_range(0, 1) == 1) lo[15:8] = v4_third[$urandom_range(0, 3)];
      end
      4: kind = KIND_IPV6;
      5: begin
        hi = '0;
        lo[63:32] = 32'hFFFF_0000;
      end
      6: begin
        hi = 64'h0064_FF9B_0000_0000;
        lo[63:32] = '0;
      end
      7: hi[63:48] = 16'h2002;
      8: hi[63:32] = 32'h2001_0000;
      9: hi[63:32] = 32'h2001_0470;
      10: begin
        if ($urandom_range(0, 1) == 1) hi[63:32] = 32'h2001_0DB8;
        else hi[63:40] = 24'h20_0100;
      end
      11: begin
        case ($urandom_range(0, 2))
          0: hi = 64'hFE80_0000_0000_0000;
          1: hi[63:48] = 16'hFE80;
          default: hi[63:57] = 7'b1111_110;
        endcase
      end
      12: begin
        hi = '0;
        case ($urandom_range(0, 3))
          0: lo = 64'd1;
          1: lo = 64'($urandom_range(0, 3));
          2: begin
            hi = 64'hFF;
            lo[63:56] = 8'hFF;
          end
          default: lo[63:32] = '0;
        endcase
      end
      13: kind = KIND_ONION;
      14: kind = KIND_INTERNAL;
      default: begin
        kind = KIND_IPV4;
        lo[31:0] = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
    endcase
    if ($urandom_range(0, 7) == 0) hi[$urandom_range(0, 63)] ^= 1'b1;
  endtask

  // Called just after a rising edge; returns at the edge that takes the beat.
  task automatic send_beat(input logic [1:0] kind, input logic [63:0] hi,
                           input logic [63:0] lo, input logic typed,
                           input peer_group_t fixed);
    peer_group_t want;
    while (tx_gaps && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    net_kind <= kind;
    addr_high <= hi;
    addr_low <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = typed ? fixed : classify_peer(kind, hi, lo, allow_private);
    expected_groups = {expected_groups, want};
    beats_sent++;
  endtask

  task automatic write_private_enable(input logic value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    allow_private = value;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_group();
    peer_group_t want;
    if (expected_groups.size() == 0) begin
      $error("result beat with nothing expected: class %0d, length %0d", peer_class,
             group_len);
      mismatches++;
    end else begin
      want = expected_groups.pop_front();
      compare_field("peer_class", 64'(want.peer_class), 64'(peer_class));
      compare_field("is_valid", 64'(want.valid_addr), 64'(is_valid));
      compare_field("is_routable", 64'(want.routable), 64'(is_routable));
      compare_field("is_local", 64'(want.local_addr), 64'(is_local));
      compare_field("group_len", 64'(want.group_len), 64'(group_len));
      compare_field("group_high", want.group_high, group_high);
      compare_field("group_low", 64'(want.group_low), 64'(group_low));
      class_seen[want.peer_class]++;
    end
  endtask

  // Result side: check what was taken at this edge, then choose the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_group();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= (hold_left != 0) || (rx_gaps && $urandom_range(0, 99) < 27);
      if (hold_left != 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("peer_address_group_classifier_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    logic [1:0]  kind;
    logic [63:0] hi;
    logic [63:0] lo;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].kind, directed_rows[i].addr_hi, directed_rows[i].addr_lo,
                directed_rows[i].typed, directed_rows[i].group);

    for (int p = 0; p < 4; p++) begin
      // The enable is only changed once the pipeline has drained.
      in_valid <= 1'b0;
      while (expected_groups.size() != 0) @(posedge clk);
      write_private_enable(PHASE_ENABLE[p]);
      tx_gaps = (p != 2);
      rx_gaps = (p != 2);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        draw_address(kind, hi, lo);
        send_beat(kind, hi, lo, 1'b0, '0);
        if (p == 1 && i == 60) hold_req = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d address beats: directed cases, then four random phases",
             beats_sent);
    $display("with the private-range enable toggled; classes 0..4 seen %0d %0d %0d %0d %0d.",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
    if (mismatches == 0)
      $display("peer_address_group_classifier_top_test: done, clean");
    else
      $display("peer_address_group_classifier_top_test: done, errors");
    $finish;
  end

endmodule

FILE: peer_address_group_classifier_top.f
src/pagc_pkg.sv
src/pagc_decode.sv
src/peer_address_group_classifier_top.sv
bench/peer_address_group_classifier_top_test.sv
